FILE: hw/rtl/bsfd_pkg.sv
// Shared types and constants for the byte-stuffed frame decoder.
`timescale 1ns / 1ps

package bsfd_pkg;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int INDEX_W = 2;

    // Register indexes on the configuration port
    localparam logic [INDEX_W-1:0] CFG_START_CODE  = 2'd0;
    localparam logic [INDEX_W-1:0] CFG_STOP_CODE   = 2'd1;
    localparam logic [INDEX_W-1:0] CFG_ESCAPE_CODE = 2'd2;
    localparam logic [INDEX_W-1:0] CFG_MAX_PAYLOAD = 2'd3;

    // Reset values of the configuration registers
    localparam logic [BYTE_W-1:0] RST_START_CODE  = 8'd18;
    localparam logic [BYTE_W-1:0] RST_STOP_CODE   = 8'd19;
    localparam logic [BYTE_W-1:0] RST_ESCAPE_CODE = 8'd125;
    localparam logic [BYTE_W-1:0] RST_MAX_PAYLOAD = 8'd64;

    localparam logic [BYTE_W-1:0] COUNT_MAX = 8'hFF;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_READING = 2'd1,
        PH_ESCAPE  = 2'd2,
        PH_ERROR   = 2'd3
    } t_phase;

    typedef enum logic [KIND_W-1:0] {
        KIND_BYTE  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ABORT = 2'd2
    } t_kind;

    typedef struct packed {
        logic [BYTE_W-1:0] start_code;
        logic [BYTE_W-1:0] stop_code;
        logic [BYTE_W-1:0] escape_code;
        logic [BYTE_W-1:0] max_payload;
    } t_cfg;

    typedef struct packed {
        logic              valid;
        t_kind             kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] frame_length;
    } t_result;

endpackage

FILE: hw/rtl/bsfd_cfg_regs.sv
// Configuration register bank: framing codes and payload size limit.
`timescale 1ns / 1ps

module bsfd_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bsfd_pkg::INDEX_W-1:0] i_cfg_index,
    input  logic [bsfd_pkg::BYTE_W-1:0]  i_cfg_data,
    output bsfd_pkg::t_cfg              o_cfg
);

    bsfd_pkg::t_cfg r_cfg;

    // Write the addressed register; reset restores the default codes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_code  <= bsfd_pkg::RST_START_CODE;
            r_cfg.stop_code   <= bsfd_pkg::RST_STOP_CODE;
            r_cfg.escape_code <= bsfd_pkg::RST_ESCAPE_CODE;
            r_cfg.max_payload <= bsfd_pkg::RST_MAX_PAYLOAD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bsfd_pkg::CFG_START_CODE:  r_cfg.start_code  <= i_cfg_data;
                bsfd_pkg::CFG_STOP_CODE:   r_cfg.stop_code   <= i_cfg_data;
                bsfd_pkg::CFG_ESCAPE_CODE: r_cfg.escape_code <= i_cfg_data;
                bsfd_pkg::CFG_MAX_PAYLOAD: r_cfg.max_payload <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hw/rtl/bsfd_fsm.sv
// Deframing state machine: phase and payload count, one byte per step.
`timescale 1ns / 1ps

module bsfd_fsm (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic [bsfd_pkg::BYTE_W-1:0] i_byte,
    input  bsfd_pkg::t_cfg             i_cfg,
    output bsfd_pkg::t_result          o_result
);

    bsfd_pkg::t_phase            r_phase, n_phase;
    logic [bsfd_pkg::BYTE_W-1:0] r_count, n_count;
    logic [bsfd_pkg::BYTE_W-1:0] count_inc;

    // Saturating increment of the payload count
    assign count_inc = (r_count == bsfd_pkg::COUNT_MAX) ? r_count : r_count + 8'd1;

    // Advance phase on each byte and build its result
    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        o_result = '{valid: 1'b0, kind: bsfd_pkg::KIND_BYTE,
                     payload_byte: '0, frame_length: '0};
        unique case (r_phase)
            bsfd_pkg::PH_IDLE: begin
                if (i_byte == i_cfg.start_code) begin
                    n_phase = bsfd_pkg::PH_READING;
                    n_count = '0;
                end
            end
            bsfd_pkg::PH_READING: begin
                priority if (r_count > i_cfg.max_payload) begin
                    n_phase        = bsfd_pkg::PH_ERROR;
                    o_result.valid = 1'b1;
                    o_result.kind  = bsfd_pkg::KIND_ABORT;
                end else if (i_byte == i_cfg.stop_code) begin
                    n_phase               = bsfd_pkg::PH_IDLE;
                    o_result.valid        = 1'b1;
                    o_result.kind         = bsfd_pkg::KIND_DONE;
                    o_result.frame_length = r_count;
                end else if (i_byte == i_cfg.escape_code) begin
                    n_phase = bsfd_pkg::PH_ESCAPE;
                end else begin
                    n_count               = count_inc;
                    o_result.valid        = 1'b1;
                    o_result.payload_byte = i_byte;
                end
            end
            bsfd_pkg::PH_ESCAPE: begin
                if (r_count >= i_cfg.max_payload) begin
                    n_phase        = bsfd_pkg::PH_ERROR;
                    o_result.valid = 1'b1;
                    o_result.kind  = bsfd_pkg::KIND_ABORT;
                end else begin
                    n_phase               = bsfd_pkg::PH_READING;
                    n_count               = count_inc;
                    o_result.valid        = 1'b1;
                    o_result.payload_byte = i_byte;
                end
            end
            bsfd_pkg::PH_ERROR: begin
                // Swallow one byte, then wait for the next frame
                n_phase = bsfd_pkg::PH_IDLE;
                n_count = '0;
            end
            default: ;
        endcase
    end

    // Hold state unless a byte is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= bsfd_pkg::PH_IDLE;
            r_count <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

endmodule

FILE: hw/rtl/byte_stuffed_frame_decoder.sv
// Byte-stuffed frame decoder top level: input register, state machine, result register.
`timescale 1ns / 1ps

// Removes start/stop/escape byte stuffing from a received byte stream. Each
// beat on the input carries one byte; each byte gives at most one result beat:
// a payload byte (kind 0), a frame-complete marker with the payload length
// (kind 1), or an abort marker when the payload size limit trips (kind 2).
// One byte is taken every cycle unless the input is stalled; a byte passes
// through an input register and the state machine into a result register,
// where its result is presented until it is taken at an edge at which the
// output is not stalled. Write the framing codes and limit only while no bytes
// are in flight.

module byte_stuffed_frame_decoder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [bsfd_pkg::BYTE_W-1:0]  i_rx_byte,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [bsfd_pkg::KIND_W-1:0]  o_kind,
    output logic [bsfd_pkg::BYTE_W-1:0]  o_payload_byte,
    output logic [bsfd_pkg::BYTE_W-1:0]  o_frame_length,
    input  logic                        i_cfg_we,
    input  logic [bsfd_pkg::INDEX_W-1:0] i_cfg_index,
    input  logic [bsfd_pkg::BYTE_W-1:0]  i_cfg_data
);

    bsfd_pkg::t_cfg              cfg;
    bsfd_pkg::t_result           result;
    logic                        r_in_valid;
    logic [bsfd_pkg::BYTE_W-1:0] r_in_byte;
    bsfd_pkg::t_result           r_out;
    logic                        out_free;
    logic                        step;
    logic                        in_take;

    bsfd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bsfd_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Handshake: result register frees when empty or taken downstream
    assign out_free   = !r_out.valid || !i_out_stall;
    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    // Input register: capture a new beat when empty or when the held byte moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // Result register: load the state machine's result, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else if (out_free) begin
            r_out.valid <= step && result.valid;
        end
        if (out_free) begin
            r_out.kind         <= result.kind;
            r_out.payload_byte <= result.payload_byte;
            r_out.frame_length <= result.frame_length;
        end
    end

    assign o_out_valid    = r_out.valid;
    assign o_kind         = r_out.kind;
    assign o_payload_byte = r_out.payload_byte;
    assign o_frame_length = r_out.frame_length;

endmodule
